>>> sv/hpbe_pkg.sv
// Package for the histogram percent bar engine: widths, sequencer step codes,
// control word layout and the microcode ROM.
// No dependencies.
package hpbe_pkg;

    localparam int BIN_BITS    = 4;
    localparam int COUNT_BITS  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int PCT_BITS    = 7;
    localparam int LEVEL_BITS  = 4;
    localparam int NUM_BINS    = 1 << BIN_BITS;
    // count * 100 fits in COUNT_BITS + 7 bits
    localparam int PROD_BITS   = COUNT_BITS + PCT_BITS;
    // divisor pre-shifted by the top quotient bit position
    localparam int DSR_BITS    = COUNT_BITS + PCT_BITS - 1;
    localparam int QCNT_BITS   = 3;
    localparam int STEP_BITS   = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [BIN_BITS-1:0]   LAST_BIN   = '1;
    localparam logic [PCT_BITS-1:0]   PCT_SCALE  = PCT_BITS'(100);
    localparam logic [PCT_BITS-1:0]   PCT_LIMIT  = PCT_BITS'(100);
    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = LEVEL_BITS'(8);
    localparam logic [QCNT_BITS-1:0]  QBIT_TOP   = QCNT_BITS'(PCT_BITS - 1);

    typedef logic [STEP_BITS-1:0] step_t;

    // Microprogram step addresses
    localparam step_t S_LOAD = 3'd0;  // read bin, form count*100, arm divider
    localparam step_t S_DIV  = 3'd1;  // one quotient bit per pass
    localparam step_t S_OUT  = 3'd2;  // present result, hold until taken
    localparam step_t S_NEXT = 3'd3;  // advance bin, loop or finish
    localparam step_t S_IDLE = 3'd4;  // wait for an input request
    localparam step_t S_UPD  = 3'd5;  // count the event

    // Jump conditions: taken -> target, else step + 1
    typedef enum logic [2:0] {
        C_NEVER   = 3'd0,
        C_ALWAYS  = 3'd1,
        C_NO_IN   = 3'd2,
        C_DIV_RUN = 3'd3,
        C_NO_OUT  = 3'd4,
        C_MORE    = 3'd5
    } jcond_t;

    typedef struct packed {
        logic   in_rdy;     // accept input request this step
        logic   out_vld;    // result is valid this step
        logic   count_upd;  // update bin and total counts
        logic   div_load;   // load dividend and divisor
        logic   div_step;   // one restoring division step
        logic   bin_inc;    // advance bin address
        jcond_t cond;
        step_t  target;
    } uword_t;

    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        w = '{in_rdy: 1'b0, out_vld: 1'b0, count_upd: 1'b0, div_load: 1'b0,
              div_step: 1'b0, bin_inc: 1'b0, cond: C_NEVER, target: S_IDLE};
        case (s)
            S_LOAD: begin
                w.div_load = 1'b1;
            end
            S_DIV: begin
                w.div_step = 1'b1;
                w.cond     = C_DIV_RUN;
                w.target   = S_DIV;
            end
            S_OUT: begin
                w.out_vld = 1'b1;
                w.cond    = C_NO_OUT;
                w.target  = S_OUT;
            end
            S_NEXT: begin
                w.bin_inc = 1'b1;
                w.cond    = C_MORE;
                w.target  = S_LOAD;
            end
            S_IDLE: begin
                w.in_rdy = 1'b1;
                w.cond   = C_NO_IN;
                w.target = S_IDLE;
            end
            S_UPD: begin
                w.count_upd = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = S_LOAD;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> sv/histogram_percent_bar_engine_core.sv
// Histogram percent bar engine top level: microcode sequencer, bin store
// and iterative percentage divider.
// Depends on hpbe_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready, s_timer_sample): one request per event.
//   The low 4 bits of the timer sample pick the bin; bin and total counts
//   go up by one and saturate. When the total is already saturated the
//   event is not counted and every result of it carries m_dropped = 1.
//   Result channel (m_valid/m_ready): 16 results per event, bin 0 first,
//   m_last_bin marks bin 15. Each carries bin*100/total and two bar levels.
//   Timing: s_ready is high only while the sequencer idles. A taken request
//   goes through a count-update step, then for each bin the steps load,
//   divider passes (one per quotient bit), present and advance; no new
//   request is taken until the sweep of all bins is done.
//   A stalled receiver holds the sequencer on the present step; the result
//   stays on the ports unchanged until taken.
//   Reset (aresetn low, synchronous) clears all bin counts and the total
//   and returns the sequencer to its idle step.
module histogram_percent_bar_engine_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [hpbe_pkg::SAMPLE_BITS-1:0]    s_timer_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hpbe_pkg::BIN_BITS-1:0]       m_bin_index,
    output logic [hpbe_pkg::PCT_BITS-1:0]       m_percent,
    output logic [hpbe_pkg::LEVEL_BITS-1:0]     m_lower_level,
    output logic [hpbe_pkg::LEVEL_BITS-1:0]     m_upper_level,
    output logic [hpbe_pkg::COUNT_BITS-1:0]     m_total_events,
    output logic                                m_dropped,
    output logic                                m_last_bin
);

    hpbe_pkg::step_t  step_reg, step_next;
    hpbe_pkg::uword_t uw;
    logic             jump;

    logic [hpbe_pkg::BIN_BITS-1:0]   addr_reg;
    logic [hpbe_pkg::COUNT_BITS-1:0] bin_mem [hpbe_pkg::NUM_BINS];
    logic [hpbe_pkg::COUNT_BITS-1:0] total_reg;
    logic                            dropped_reg;
    logic [hpbe_pkg::COUNT_BITS-1:0] bin_rd;

    logic [hpbe_pkg::PROD_BITS-1:0]  rem_reg;
    logic [hpbe_pkg::DSR_BITS-1:0]   dsr_reg;
    logic [hpbe_pkg::QCNT_BITS-1:0]  qcnt_reg;
    logic [hpbe_pkg::PCT_BITS-1:0]   quo_reg;
    logic                            fits;
    logic [hpbe_pkg::PCT_BITS-1:0]   pct;
    logic [hpbe_pkg::PCT_BITS-1:0]   pct_hi;

    // Control word for the current step
    assign uw      = hpbe_pkg::ucode_rom(step_reg);
    assign s_ready = uw.in_rdy;
    assign m_valid = uw.out_vld;

    // Jump condition select
    always_comb begin
        case (uw.cond)
            hpbe_pkg::C_NEVER:   jump = 1'b0;
            hpbe_pkg::C_ALWAYS:  jump = 1'b1;
            hpbe_pkg::C_NO_IN:   jump = !s_valid;
            hpbe_pkg::C_DIV_RUN: jump = (qcnt_reg != '0);
            hpbe_pkg::C_NO_OUT:  jump = !m_ready;
            hpbe_pkg::C_MORE:    jump = (addr_reg != hpbe_pkg::LAST_BIN);
            default:             jump = 1'b0;
        endcase
        step_next = jump ? uw.target : hpbe_pkg::step_t'(step_reg + 1'b1);
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= hpbe_pkg::S_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    assign bin_rd = bin_mem[addr_reg];

    // Bin store and event counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < hpbe_pkg::NUM_BINS; i++) begin
                bin_mem[i] <= '0;
            end
            total_reg   <= '0;
            dropped_reg <= 1'b0;
        end else if (uw.count_upd) begin
            if (total_reg == hpbe_pkg::COUNT_MAX) begin
                dropped_reg <= 1'b1;
            end else begin
                dropped_reg <= 1'b0;
                total_reg   <= total_reg + 1'b1;
                if (bin_rd != hpbe_pkg::COUNT_MAX) begin
                    bin_mem[addr_reg] <= bin_rd + 1'b1;
                end
            end
        end
    end

    // Bin address: event bin on request, then sweep 0..last
    always_ff @(posedge aclk) begin
        if (uw.in_rdy && s_valid) begin
            addr_reg <= s_timer_sample[hpbe_pkg::BIN_BITS-1:0];
        end else if (uw.count_upd) begin
            addr_reg <= '0;
        end else if (uw.bin_inc) begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    // Restoring divider, one quotient bit per step, MSB first
    assign fits = (rem_reg >= {1'b0, dsr_reg}) && (total_reg != '0);

    always_ff @(posedge aclk) begin
        if (uw.div_load) begin
            rem_reg  <= hpbe_pkg::PROD_BITS'(bin_rd)
                      * hpbe_pkg::PROD_BITS'(hpbe_pkg::PCT_SCALE);
            dsr_reg  <= {total_reg, {(hpbe_pkg::PCT_BITS-1){1'b0}}};
            qcnt_reg <= hpbe_pkg::QBIT_TOP;
            quo_reg  <= '0;
        end else if (uw.div_step) begin
            if (fits) begin
                rem_reg <= rem_reg - {1'b0, dsr_reg};
            end
            dsr_reg  <= dsr_reg >> 1;
            qcnt_reg <= qcnt_reg - 1'b1;
            quo_reg  <= {quo_reg[hpbe_pkg::PCT_BITS-2:0], fits};
        end
    end

    // Percentage clip and bar levels
    always_comb begin
        pct    = (quo_reg > hpbe_pkg::PCT_LIMIT) ? hpbe_pkg::PCT_LIMIT : quo_reg;
        pct_hi = (pct > hpbe_pkg::PCT_BITS'(hpbe_pkg::LEVEL_FULL))
               ? pct - hpbe_pkg::PCT_BITS'(hpbe_pkg::LEVEL_FULL) : '0;
        m_lower_level = (pct > hpbe_pkg::PCT_BITS'(hpbe_pkg::LEVEL_FULL))
                      ? hpbe_pkg::LEVEL_FULL : pct[hpbe_pkg::LEVEL_BITS-1:0];
        m_upper_level = (pct_hi > hpbe_pkg::PCT_BITS'(hpbe_pkg::LEVEL_FULL))
                      ? hpbe_pkg::LEVEL_FULL : pct_hi[hpbe_pkg::LEVEL_BITS-1:0];
    end

    assign m_percent      = pct;
    assign m_bin_index    = addr_reg;
    assign m_total_events = total_reg;
    assign m_dropped      = dropped_reg;
    assign m_last_bin     = (addr_reg == hpbe_pkg::LAST_BIN);

endmodule
